// ----- src/lfu_pkg.sv -----
// Package for the LFU cache table: sizes, field widths, controller state,
// and the command and status types between controller and datapath.
// No dependencies; every other file imports it.
`default_nettype none

package lfu_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int OCC_W       = $clog2(MAX_ENTRIES + 1);
  localparam int CAP_W       = 5;
  localparam int CMP_W       = (OCC_W > CAP_W) ? OCC_W : CAP_W;
  localparam int KEY_W       = 32;
  localparam int DATA_W      = 32;
  localparam int COUNT_W     = 16;

  localparam logic [CAP_W-1:0]   CAP_RESET = CAP_W'(16);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic               OP_GET    = 1'b0;
  localparam logic               OP_PUT    = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic start;
    logic step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
  } status_t;

endpackage

`default_nettype wire

// ----- src/lfu_req_if.sv -----
// Request channel: op, key and data_in with a valid/ready handshake.
// Depends on lfu_pkg.
`default_nettype none

interface lfu_req_if;
  import lfu_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     op;
  logic signed [KEY_W-1:0]  key;
  logic signed [DATA_W-1:0] data_in;

  modport source (output valid, output op, output key, output data_in, input ready);
  modport sink (input valid, input op, input key, input data_in, output ready);
endinterface

`default_nettype wire

// ----- src/lfu_rsp_if.sv -----
// Response channel: hit, data_out, evicted and evicted_key with valid/ready.
// Depends on lfu_pkg.
`default_nettype none

interface lfu_rsp_if;
  import lfu_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     hit;
  logic signed [DATA_W-1:0] data_out;
  logic                     evicted;
  logic signed [KEY_W-1:0]  evicted_key;

  modport source (output valid, output hit, output data_out, output evicted,
                  output evicted_key, input ready);
  modport sink (input valid, input hit, input data_out, input evicted,
                input evicted_key, output ready);
endinterface

`default_nettype wire

// ----- src/lfu_cfg_if.sv -----
// Configuration write channel carrying the capacity register value.
// Depends on lfu_pkg.
`default_nettype none

interface lfu_cfg_if;
  import lfu_pkg::*;

  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- src/lfu_ctrl.sv -----
// Controller for the LFU cache table: sequences accept, entry scan and commit,
// and owns the response valid flag. Depends on lfu_pkg.
`default_nettype none

module lfu_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              req_valid,
  output logic             req_ready,
  output logic             rsp_valid,
  input  wire              rsp_ready,
  output lfu_pkg::cmd_t    cmd,
  input  lfu_pkg::status_t status
);
  import lfu_pkg::*;

  state_t state;
  state_t state_next;
  logic   rsp_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.start  = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.step = 1'b1;
        if (status.scan_last) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        // The result register must be free, or be emptied in this cycle.
        if (!rsp_valid || rsp_ready) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (cmd.commit) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

endmodule

`default_nettype wire

// ----- src/lfu_dpath.sv -----
// Datapath for the LFU cache table: entry storage, the one-entry-per-cycle
// scan for match, victim and free slot, the commit update and the result
// register. Depends on lfu_pkg.
`default_nettype none

module lfu_dpath (
  input  wire                             clk,
  input  wire                             rst,
  input  lfu_pkg::cmd_t                   cmd,
  output lfu_pkg::status_t                status,
  input  wire                             cfg_write,
  input  wire [lfu_pkg::CAP_W-1:0]        cfg_data,
  input  wire                             req_op,
  input  wire signed [lfu_pkg::KEY_W-1:0]  req_key,
  input  wire signed [lfu_pkg::DATA_W-1:0] req_data,
  output logic                            rsp_hit,
  output logic signed [lfu_pkg::DATA_W-1:0] rsp_data,
  output logic                            rsp_evicted,
  output logic signed [lfu_pkg::KEY_W-1:0]  rsp_evicted_key
);
  import lfu_pkg::*;

  // Entry storage.
  logic                     valid [MAX_ENTRIES];
  logic [KEY_W-1:0]         keys  [MAX_ENTRIES];
  logic [DATA_W-1:0]        vals  [MAX_ENTRIES];
  logic [COUNT_W-1:0]       count [MAX_ENTRIES];
  logic [IDX_W-1:0]         rank  [MAX_ENTRIES];
  logic [OCC_W-1:0]         occupancy;
  logic [CAP_W-1:0]         capacity;

  // Captured request.
  logic                     op;
  logic [KEY_W-1:0]         key;
  logic [DATA_W-1:0]        data;

  // Scan state.
  logic [IDX_W-1:0]         idx;
  logic                     match_found;
  logic [IDX_W-1:0]         match_idx;
  logic [IDX_W-1:0]         match_rank;
  logic [DATA_W-1:0]        match_value;
  logic                     victim_found;
  logic [IDX_W-1:0]         victim_idx;
  logic [IDX_W-1:0]         victim_rank;
  logic [COUNT_W-1:0]       victim_count;
  logic [KEY_W-1:0]         victim_key;
  logic                     free_found;
  logic [IDX_W-1:0]         free_idx;

  // Per-step and commit decisions.
  logic                     cur_valid;
  logic                     is_match;
  logic                     is_victim;
  logic                     is_free;
  logic [CMP_W-1:0]         cap_sat;
  logic                     do_insert;
  logic                     do_evict;
  logic                     do_store;
  logic [IDX_W-1:0]         ins_slot;

  assign status.scan_last = (idx == IDX_W'(MAX_ENTRIES - 1));

  always_comb begin
    cur_valid = valid[idx];
    is_match  = cur_valid && (keys[idx] == key) && !match_found;
    is_victim = cur_valid && (!victim_found || (count[idx] < victim_count) ||
                ((count[idx] == victim_count) && (rank[idx] > victim_rank)));
    is_free   = !cur_valid && !free_found;

    if (CMP_W'(capacity) > CMP_W'(MAX_ENTRIES)) begin
      cap_sat = CMP_W'(MAX_ENTRIES);
    end else begin
      cap_sat = CMP_W'(capacity);
    end
    do_insert = !match_found && (op == OP_PUT) && (cap_sat != '0);
    do_evict  = do_insert && (CMP_W'(occupancy) >= cap_sat) && victim_found;
    do_store  = do_insert && (do_evict || free_found);
    ins_slot  = do_evict ? victim_idx : free_idx;
  end

  // Control state: valid bits, occupancy, capacity and scan flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        valid[i] <= 1'b0;
      end
      occupancy    <= '0;
      capacity     <= CAP_RESET;
      idx          <= '0;
      match_found  <= 1'b0;
      victim_found <= 1'b0;
      free_found   <= 1'b0;
    end else begin
      if (cfg_write) begin
        capacity <= cfg_data;
      end
      if (cmd.start) begin
        idx          <= '0;
        match_found  <= 1'b0;
        victim_found <= 1'b0;
        free_found   <= 1'b0;
      end else if (cmd.step) begin
        idx <= idx + 1'b1;
        if (is_match) begin
          match_found <= 1'b1;
        end
        if (is_victim) begin
          victim_found <= 1'b1;
        end
        if (is_free) begin
          free_found <= 1'b1;
        end
      end
      if (cmd.commit && do_store) begin
        // An eviction followed by an insert leaves the occupancy unchanged.
        valid[ins_slot] <= 1'b1;
        if (!do_evict) begin
          occupancy <= occupancy + 1'b1;
        end
      end
    end
  end

  // Payload: request capture, scan records, entry fields and the result.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op   <= req_op;
      key  <= req_key;
      data <= req_data;
    end
    if (cmd.step) begin
      if (is_match) begin
        match_idx   <= idx;
        match_rank  <= rank[idx];
        match_value <= vals[idx];
      end
      if (is_victim) begin
        victim_idx   <= idx;
        victim_rank  <= rank[idx];
        victim_count <= count[idx];
        victim_key   <= keys[idx];
      end
      if (is_free) begin
        free_idx <= idx;
      end
    end
    if (cmd.commit) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (match_found) begin
          if (IDX_W'(i) == match_idx) begin
            rank[i] <= '0;
            if (count[i] != COUNT_MAX) begin
              count[i] <= count[i] + 1'b1;
            end
            if (op == OP_PUT) begin
              vals[i] <= data;
            end
          end else if (valid[i] && (rank[i] < match_rank)) begin
            rank[i] <= rank[i] + 1'b1;
          end
        end else if (do_store) begin
          if (IDX_W'(i) == ins_slot) begin
            keys[i]  <= key;
            vals[i]  <= data;
            count[i] <= COUNT_W'(1);
            rank[i]  <= '0;
          end else if (valid[i]) begin
            // Entries older than the victim close its gap, then all age by one.
            if (do_evict && (rank[i] > victim_rank)) begin
              rank[i] <= rank[i];
            end else begin
              rank[i] <= rank[i] + 1'b1;
            end
          end
        end
      end
      rsp_hit         <= match_found;
      rsp_data        <= (match_found && (op == OP_GET)) ? match_value : '1;
      rsp_evicted     <= do_evict;
      rsp_evicted_key <= do_evict ? victim_key : '0;
    end
  end

endmodule

`default_nettype wire

// ----- src/lfu_cache_table.sv -----
// LFU cache table, top level. Depends on lfu_pkg, lfu_req_if, lfu_rsp_if,
// lfu_cfg_if, lfu_ctrl and lfu_dpath.
//
// Usage: each request transaction on req carries a get or a put with a key and
// a value. Exactly one response transaction on rsp follows for every request:
// hit, the stored value on a get hit (else all ones), and the evicted key when
// a put of a new key into a full table replaced the least frequently used
// entry (least recently used among equal counts).
// The cfg channel writes the capacity register; it is always ready. The user
// must write it only while no request is in flight; this is not enforced.
// Sequence: a request is taken in an idle cycle, the entries are then scanned one
// per cycle (one comparator and one victim compare shared by all entries), and
// a commit state updates the table and loads the result register. A new
// request is accepted only after the previous one has been committed.
// Reset empties the table and sets the capacity to 16. When the receiver
// stalls, the result waits in its register while the next request is accepted
// and scanned; that request's commit waits until the register is taken.
`default_nettype none

module lfu_cache_table (
  input wire      clk,
  input wire      rst,
  lfu_req_if.sink req,
  lfu_rsp_if.source rsp,
  lfu_cfg_if.sink cfg
);
  import lfu_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    cfg_write;

  assign cfg.ready = 1'b1;
  assign cfg_write = cfg.valid && cfg.ready;

  lfu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd),
    .status    (status)
  );

  lfu_dpath u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_write       (cfg_write),
    .cfg_data        (cfg.data),
    .req_op          (req.op),
    .req_key         (req.key),
    .req_data        (req.data_in),
    .rsp_hit         (rsp.hit),
    .rsp_data        (rsp.data_out),
    .rsp_evicted     (rsp.evicted),
    .rsp_evicted_key (rsp.evicted_key)
  );

endmodule

`default_nettype wire
